### hdl/btls_pkg.sv
// Shared types, widths and codes of the block timestep level scheduler.
`timescale 1ns / 1ps

package btls_pkg;

   localparam int CMD_W   = 2;
   localparam int COORD_W = 4;
   localparam int LEVEL_W = 6;
   localparam int TIME_W  = 63;
   localparam int OPND_W  = LEVEL_W + 1;

   typedef logic [CMD_W-1:0]   cmd_type;
   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [TIME_W-1:0]  ticks_type;
   typedef logic [OPND_W-1:0]  opnd_type;

   localparam cmd_type CMD_SET    = 2'd0;
   localparam cmd_type CMD_STEP   = 2'd1;
   localparam cmd_type CMD_SMOOTH = 2'd2;

   // Largest level exponent, also the running minimum when no block joined it.
   localparam level_type LEVEL_CAP = 6'd60;
   localparam opnd_type  OPND_CAP  = 7'd60;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SET,
      ST_STEP_LIM,
      ST_STEP_CAP,
      ST_STEP_CLAMP,
      ST_STEP_MIN,
      ST_COPY,
      ST_COPY_END,
      ST_SELF_RD,
      ST_SELF_CHK,
      ST_NBR,
      ST_NBR_LAST,
      ST_DONE
   } state_type;

endpackage

### hdl/btls_req_if.sv
// Request channel interface carrying one command word.
`timescale 1ns / 1ps

interface btls_req_if import btls_pkg::*; ();
   logic      valid;
   logic      ready;
   cmd_type   command;
   coord_type block_x;
   coord_type block_y;
   coord_type block_z;
   level_type level_exp;
   logic      active;
   level_type cfl_limit_exp;
   level_type strength_limit_exp;
   logic      has_particles;
   ticks_type time_ticks;
   logic      first_block;

   modport source (
      output valid, command, block_x, block_y, block_z, level_exp, active,
             cfl_limit_exp, strength_limit_exp, has_particles, time_ticks,
             first_block,
      input  ready
   );

   modport sink (
      input  valid, command, block_x, block_y, block_z, level_exp, active,
             cfl_limit_exp, strength_limit_exp, has_particles, time_ticks,
             first_block,
      output ready
   );
endinterface

### hdl/btls_rsp_if.sv
// Response channel interface carrying one result word.
`timescale 1ns / 1ps

interface btls_rsp_if import btls_pkg::*; ();
   logic      valid;
   logic      ready;
   level_type block_level_exp;
   level_type min_level_exp;

   modport source (
      output valid, block_level_exp, min_level_exp,
      input  ready
   );

   modport sink (
      input  valid, block_level_exp, min_level_exp,
      output ready
   );
endinterface

### hdl/block_timestep_level_scheduler_unit.sv
// Top level of the block timestep level scheduler: sequencer, level and snapshot stores.
// After reset all GRID_X*GRID_Y*GRID_Z level entries are cleared, one entry a cycle.
// A set runs through SET and DONE, a step through STEP_LIM, STEP_CAP, STEP_CLAMP, STEP_MIN
// and DONE. Smooth copies the store into the snapshot (COPY, COPY_END), checks each block in
// SELF_RD, SELF_CHK and, for an active block, one snapshot read per neighbour in NBR.
// One word is in work at a time; the next is taken in the cycle after the result is registered.
`timescale 1ns / 1ps

module block_timestep_level_scheduler_unit import btls_pkg::*; #(
   parameter int GRID_X = 16,
   parameter int GRID_Y = 16,
   parameter int GRID_Z = 16
) (
   input  logic    clock,
   input  logic    reset,
   btls_req_if.sink   req_if,
   btls_rsp_if.source rsp_if
);

   localparam int NBLOCKS  = GRID_X * GRID_Y * GRID_Z;
   localparam int IW       = (NBLOCKS > 1) ? $clog2(NBLOCKS) : 1;
   localparam int XW       = (GRID_X > 1) ? $clog2(GRID_X) : 1;
   localparam int YW       = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
   localparam int ZW       = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
   localparam int STRIDE_X = GRID_Y * GRID_Z;
   localparam int STRIDE_Y = GRID_Z;

   localparam logic [IW-1:0] LAST_IDX = IW'(NBLOCKS - 1);
   localparam logic [XW-1:0] LAST_X   = XW'(GRID_X - 1);
   localparam logic [YW-1:0] LAST_Y   = YW'(GRID_Y - 1);
   localparam logic [ZW-1:0] LAST_Z   = ZW'(GRID_Z - 1);

   // Neighbour offset codes along one axis.
   localparam logic [1:0] OFF_MINUS = 2'd0;
   localparam logic [1:0] OFF_ZERO  = 2'd1;
   localparam logic [1:0] OFF_PLUS  = 2'd2;

   // Sequencer state and counters.
   state_type     state_ff, state_in;
   logic [IW-1:0] self_idx_ff, self_idx_in;
   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic [ZW-1:0] z_ff, z_in;
   logic [1:0]    dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic          nb_vld_ff, nb_vld_in;
   level_type     best_ff, best_in;

   // Working values of a step or set.
   level_type     lvl_ff, lvl_in;
   logic          act_ff, act_in;
   logic          tick_ff, tick_in;
   level_type     lim_ff, lim_in;
   level_type     block_ff, block_in;
   level_type     run_min_ff, run_min_in;

   // Request word held for the duration of the command.
   logic [IW-1:0] idx_ff;
   level_type     set_lvl_ff;
   logic          set_act_ff;
   level_type     cfl_ff;
   level_type     str_ff;
   logic          part_ff;
   ticks_type     time_ff;

   // Result register.
   logic          rsp_valid_ff, rsp_valid_in;
   level_type     rsp_blk_ff, rsp_min_ff;
   logic          load_rsp;

   // Store ports.
   logic          lvl_we;
   logic [IW-1:0] lvl_wa, lvl_ra;
   opnd_type      lvl_wd, lvl_rd;
   logic          snap_we_ff, snap_we_in;
   logic [IW-1:0] snap_wa_ff, snap_wa_in;
   logic [IW-1:0] snap_ra;
   opnd_type      snap_rd;

   // Shared compare unit.
   opnd_type      alu_a, alu_b, alu_y;

   logic          req_accept;
   logic          req_inside;
   logic [IW-1:0] req_idx;
   logic [IW-1:0] nbr_idx;
   logic          nbr_ok;
   logic [IW-1:0] adv_idx;
   logic [XW-1:0] adv_x;
   logic [YW-1:0] adv_y;
   logic [ZW-1:0] adv_z;
   logic          last_block;
   logic          last_nbr;
   level_type     best_next;
   ticks_type     tick_mask;

   assign req_accept = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);

   assign req_inside = ({3'b000, req_if.block_x} < 7'(GRID_X)) &&
                       ({3'b000, req_if.block_y} < 7'(GRID_Y)) &&
                       ({3'b000, req_if.block_z} < 7'(GRID_Z));
   assign req_idx = IW'((int'(req_if.block_x) * GRID_Y + int'(req_if.block_y)) * GRID_Z +
                        int'(req_if.block_z));

   // The level store holds the active flag in its top bit and the level below it.
   btls_ram #(.WIDTH(OPND_W), .DEPTH(NBLOCKS)) u_level_ram (
      .clock   (clock),
      .wr_en   (lvl_we),
      .wr_addr (lvl_wa),
      .wr_data (lvl_wd),
      .rd_addr (lvl_ra),
      .rd_data (lvl_rd)
   );

   // The snapshot takes a copy of the level store at the start of every smoothing pass.
   btls_ram #(.WIDTH(OPND_W), .DEPTH(NBLOCKS)) u_snap_ram (
      .clock   (clock),
      .wr_en   (snap_we_ff),
      .wr_addr (snap_wa_ff),
      .wr_data (lvl_rd),
      .rd_addr (snap_ra),
      .rd_data (snap_rd)
   );

   btls_min_unit u_min (
      .a (alu_a),
      .b (alu_b),
      .y (alu_y)
   );

   // The step doubles when the low lvl bits of the time count are all clear.
   assign tick_mask = (TIME_W'(1) << lvl_ff) - TIME_W'(1);

   // Neighbour address and grid test for the current offset.
   always_comb begin
      nbr_idx = self_idx_ff;
      nbr_ok  = 1'b1;
      if (dx_ff == OFF_MINUS) begin
         nbr_idx = nbr_idx - IW'(STRIDE_X);
         nbr_ok  = nbr_ok && (x_ff != '0);
      end else if (dx_ff == OFF_PLUS) begin
         nbr_idx = nbr_idx + IW'(STRIDE_X);
         nbr_ok  = nbr_ok && (x_ff != LAST_X);
      end
      if (dy_ff == OFF_MINUS) begin
         nbr_idx = nbr_idx - IW'(STRIDE_Y);
         nbr_ok  = nbr_ok && (y_ff != '0);
      end else if (dy_ff == OFF_PLUS) begin
         nbr_idx = nbr_idx + IW'(STRIDE_Y);
         nbr_ok  = nbr_ok && (y_ff != LAST_Y);
      end
      if (dz_ff == OFF_MINUS) begin
         nbr_idx = nbr_idx - IW'(1);
         nbr_ok  = nbr_ok && (z_ff != '0);
      end else if (dz_ff == OFF_PLUS) begin
         nbr_idx = nbr_idx + IW'(1);
         nbr_ok  = nbr_ok && (z_ff != LAST_Z);
      end
   end

   // Next block of the grid walk, z fastest.
   always_comb begin
      adv_idx = self_idx_ff + IW'(1);
      adv_x   = x_ff;
      adv_y   = y_ff;
      adv_z   = z_ff + ZW'(1);
      if (z_ff == LAST_Z) begin
         adv_z = '0;
         adv_y = y_ff + YW'(1);
         if (y_ff == LAST_Y) begin
            adv_y = '0;
            adv_x = x_ff + XW'(1);
         end
      end
   end

   assign last_block = (self_idx_ff == LAST_IDX);
   assign last_nbr   = (dx_ff == OFF_PLUS) && (dy_ff == OFF_PLUS) && (dz_ff == OFF_PLUS);
   assign best_next  = nb_vld_ff ? alu_y[LEVEL_W-1:0] : best_ff;

   always_comb begin
      state_in    = state_ff;
      self_idx_in = self_idx_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      z_in        = z_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      dz_in       = dz_ff;
      nb_vld_in   = 1'b0;
      best_in     = best_next;
      lvl_in      = lvl_ff;
      act_in      = act_ff;
      tick_in     = tick_ff;
      lim_in      = lim_ff;
      block_in    = block_ff;
      run_min_in  = run_min_ff;
      load_rsp    = 1'b0;
      lvl_we      = 1'b0;
      lvl_wa      = idx_ff;
      lvl_wd      = '0;
      lvl_ra      = req_idx;
      snap_ra     = self_idx_ff;
      snap_we_in  = 1'b0;
      snap_wa_in  = self_idx_ff;
      // While walking neighbours the unit compares the candidate with the best so far.
      alu_a       = {1'b0, snap_rd[LEVEL_W-1:0]} + OPND_W'(1);
      alu_b       = {1'b0, best_ff};

      unique case (state_ff)
         ST_CLEAR: begin
            lvl_we = 1'b1;
            lvl_wa = self_idx_ff;
            lvl_wd = '0;
            if (last_block) begin
               self_idx_in = '0;
               state_in    = ST_IDLE;
            end else begin
               self_idx_in = self_idx_ff + IW'(1);
            end
         end

         ST_IDLE: begin
            if (req_accept) begin
               block_in = '0;
               unique case (req_if.command)
                  CMD_SET: begin
                     state_in = req_inside ? ST_SET : ST_DONE;
                  end
                  CMD_STEP: begin
                     if (req_if.first_block) begin
                        run_min_in = LEVEL_CAP;
                     end
                     state_in = req_inside ? ST_STEP_LIM : ST_DONE;
                  end
                  CMD_SMOOTH: begin
                     self_idx_in = '0;
                     x_in        = '0;
                     y_in        = '0;
                     z_in        = '0;
                     state_in    = ST_COPY;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_SET: begin
            alu_a    = {1'b0, set_lvl_ff};
            alu_b    = OPND_CAP;
            lvl_we   = 1'b1;
            lvl_wd   = {set_act_ff, alu_y[LEVEL_W-1:0]};
            block_in = alu_y[LEVEL_W-1:0];
            state_in = ST_DONE;
         end

         ST_STEP_LIM: begin
            lvl_in   = lvl_rd[LEVEL_W-1:0];
            act_in   = lvl_rd[LEVEL_W];
            alu_a    = {1'b0, cfl_ff};
            alu_b    = {1'b0, str_ff};
            lim_in   = alu_y[LEVEL_W-1:0];
            state_in = ST_STEP_CAP;
         end

         ST_STEP_CAP: begin
            alu_a    = {1'b0, lim_ff};
            alu_b    = OPND_CAP;
            lim_in   = alu_y[LEVEL_W-1:0];
            tick_in  = ((time_ff & tick_mask) == '0);
            state_in = ST_STEP_CLAMP;
         end

         ST_STEP_CLAMP: begin
            alu_a    = {1'b0, lvl_ff} + OPND_W'(tick_ff);
            alu_b    = {1'b0, lim_ff};
            lvl_we   = 1'b1;
            lvl_wd   = {act_ff, alu_y[LEVEL_W-1:0]};
            block_in = alu_y[LEVEL_W-1:0];
            state_in = ST_STEP_MIN;
         end

         ST_STEP_MIN: begin
            alu_a = {1'b0, block_ff};
            alu_b = {1'b0, run_min_ff};
            if (part_ff) begin
               run_min_in = alu_y[LEVEL_W-1:0];
            end
            state_in = ST_DONE;
         end

         ST_COPY: begin
            lvl_ra     = self_idx_ff;
            snap_we_in = 1'b1;
            snap_wa_in = self_idx_ff;
            if (last_block) begin
               self_idx_in = '0;
               state_in    = ST_COPY_END;
            end else begin
               self_idx_in = self_idx_ff + IW'(1);
            end
         end

         ST_COPY_END: begin
            // The last snapshot write lands in this cycle.
            state_in = ST_SELF_RD;
         end

         ST_SELF_RD: begin
            state_in = ST_SELF_CHK;
         end

         ST_SELF_CHK: begin
            if (snap_rd[LEVEL_W]) begin
               best_in  = snap_rd[LEVEL_W-1:0];
               dx_in    = OFF_MINUS;
               dy_in    = OFF_MINUS;
               dz_in    = OFF_MINUS;
               state_in = ST_NBR;
            end else if (last_block) begin
               state_in = ST_DONE;
            end else begin
               self_idx_in = adv_idx;
               x_in        = adv_x;
               y_in        = adv_y;
               z_in        = adv_z;
               state_in    = ST_SELF_RD;
            end
         end

         ST_NBR: begin
            snap_ra   = nbr_idx;
            nb_vld_in = nbr_ok;
            if (last_nbr) begin
               state_in = ST_NBR_LAST;
            end else if (dz_ff == OFF_PLUS) begin
               dz_in = OFF_MINUS;
               if (dy_ff == OFF_PLUS) begin
                  dy_in = OFF_MINUS;
                  dx_in = dx_ff + 2'd1;
               end else begin
                  dy_in = dy_ff + 2'd1;
               end
            end else begin
               dz_in = dz_ff + 2'd1;
            end
         end

         ST_NBR_LAST: begin
            lvl_we = 1'b1;
            lvl_wa = self_idx_ff;
            lvl_wd = {1'b1, best_next};
            if (last_block) begin
               state_in = ST_DONE;
            end else begin
               self_idx_in = adv_idx;
               x_in        = adv_x;
               y_in        = adv_y;
               z_in        = adv_z;
               state_in    = ST_SELF_RD;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         self_idx_ff  <= '0;
         nb_vld_ff    <= 1'b0;
         snap_we_ff   <= 1'b0;
         run_min_ff   <= LEVEL_CAP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         self_idx_ff  <= self_idx_in;
         nb_vld_ff    <= nb_vld_in;
         snap_we_ff   <= snap_we_in;
         run_min_ff   <= run_min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      dz_ff      <= dz_in;
      best_ff    <= best_in;
      lvl_ff     <= lvl_in;
      act_ff     <= act_in;
      tick_ff    <= tick_in;
      lim_ff     <= lim_in;
      block_ff   <= block_in;
      snap_wa_ff <= snap_wa_in;
      if (req_accept) begin
         idx_ff     <= req_idx;
         set_lvl_ff <= req_if.level_exp;
         set_act_ff <= req_if.active;
         cfl_ff     <= req_if.cfl_limit_exp;
         str_ff     <= req_if.strength_limit_exp;
         part_ff    <= req_if.has_particles;
         time_ff    <= req_if.time_ticks;
      end
      if (load_rsp) begin
         rsp_blk_ff <= block_ff;
         rsp_min_ff <= run_min_ff;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.block_level_exp = rsp_blk_ff;
   assign rsp_if.min_level_exp   = rsp_min_ff;

`ifndef SYNTHESIS
   // The running minimum never rises above the level cap.
   a_rmin_cap: assert property (@(posedge clock) disable iff (reset)
      run_min_ff <= LEVEL_CAP)
      else $error("running minimum above level cap");

   // Every level written into the store respects the cap.
   a_lvl_wr_cap: assert property (@(posedge clock) disable iff (reset)
      lvl_we |-> (lvl_wd[LEVEL_W-1:0] <= LEVEL_CAP))
      else $error("level store written above cap");

   // A loaded result shows up on the response channel in the next cycle.
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (rsp_if.valid && (rsp_if.block_level_exp == $past(block_ff))))
      else $error("result word not presented after load");

   // Snapshot writes only trail the copy sweep.
   a_snap_copy: assert property (@(posedge clock) disable iff (reset)
      snap_we_ff |-> ((state_ff == ST_COPY) || (state_ff == ST_COPY_END)))
      else $error("snapshot written outside the copy sweep");
`endif

endmodule

### hdl/btls_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module btls_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/btls_min_unit.sv
// Shared compare-and-select unit giving the smaller of two level operands.
`timescale 1ns / 1ps

module btls_min_unit import btls_pkg::*; (
   input  opnd_type a,
   input  opnd_type b,
   output opnd_type y
);

   logic a_lt_b;

   assign a_lt_b = (a < b);
   assign y      = a_lt_b ? a : b;

endmodule
